[src/obbp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// obbp_pkg
// Shared types and constants for the order book best price tracker:
// request and response payloads, table word layouts and result codes.
// ----------------------------------------------------------------------------
package obbp_pkg;

    // Default table sizes.
    localparam int DEF_ORDER_SLOTS  = 64;
    localparam int DEF_PRICE_LEVELS = 64;

    // Field widths fixed by the interface.
    localparam int ID_W    = 32;
    localparam int PRICE_W = 32;
    localparam int CNT_W   = 7;

    // Ceiling of the per-level order count.
    localparam logic [CNT_W-1:0] COUNT_MAX = 7'd127;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_ERASE  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_APPLIED = 2'd0,
        ST_DUP     = 2'd1,
        ST_UNKNOWN = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd               cmd;
        logic [ID_W-1:0]    ord_key;
        logic [PRICE_W-1:0] price;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic               has_price;
        logic [PRICE_W-1:0] best_price;
    } t_rsp;

    // One order slot as stored in memory.
    typedef struct packed {
        logic               live;
        logic [ID_W-1:0]    id;
        logic [PRICE_W-1:0] price;
    } t_slot_word;

    // One price level as stored in memory.
    typedef struct packed {
        logic               live;
        logic [CNT_W-1:0]   orders;
        logic [PRICE_W-1:0] price;
    } t_lvl_word;

    // Outputs of the shared comparator.
    typedef struct packed {
        logic eq;
        logic gt;
    } t_cmp_res;

endpackage : obbp_pkg
`default_nettype wire

[src/order_book_best_price.sv]
`default_nettype none
// Each request runs linear scans of the slot and level memories, one entry
// per cycle through one read port per memory and one shared comparator.
// Requests are handled one at a time; the next one is taken while a result
// waits in the output register.
// Reset: a clearing pass over both tables, no request taken.
// ----------------------------------------------------------------------------
// order_book_best_price
// Limit order book top-of-book tracker: inserts and erases orders by id,
// keeps per-price order counts and answers the highest live price.
// ----------------------------------------------------------------------------
module order_book_best_price #(
    parameter int ORDER_SLOTS  = obbp_pkg::DEF_ORDER_SLOTS,
    parameter int PRICE_LEVELS = obbp_pkg::DEF_PRICE_LEVELS
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire obbp_pkg::t_req i_in_req,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output obbp_pkg::t_rsp      o_out_rsp
);
    import obbp_pkg::*;

    localparam int SAW       = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
    localparam int LAW       = (PRICE_LEVELS > 1) ? $clog2(PRICE_LEVELS) : 1;
    localparam int MAX_DEPTH = (ORDER_SLOTS > PRICE_LEVELS) ? ORDER_SLOTS : PRICE_LEVELS;
    localparam int CW        = $clog2(MAX_DEPTH + 1);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_SLOT  = 7'b0000100,
        S_LVL   = 7'b0001000,
        S_UPD   = 7'b0010000,
        S_MAX   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    // Control registers.
    t_state         r_state, n_state;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           r_rd_v, n_rd_v;
    logic           r_out_valid, n_out_valid;
    logic           r_any, n_any;
    logic [PRICE_W-1:0] r_best, n_best;

    // Working registers of the current request.
    logic [CW-1:0]      r_rd_idx, n_rd_idx;
    t_req               r_req, n_req;
    logic [PRICE_W-1:0] r_target, n_target;
    logic [SAW-1:0]     r_slot_idx, n_slot_idx;
    logic               r_free_hit, n_free_hit;
    logic [SAW-1:0]     r_free_idx, n_free_idx;
    logic               r_lvl_hit, n_lvl_hit;
    logic [LAW-1:0]     r_lvl_idx, n_lvl_idx;
    logic [CNT_W-1:0]   r_lvl_orders, n_lvl_orders;
    logic               r_lfree_hit, n_lfree_hit;
    logic [LAW-1:0]     r_lfree_idx, n_lfree_idx;
    t_status            r_status, n_status;
    t_rsp               r_out, n_out;

    // Memory ports.
    logic                         slot_we;
    logic [SAW-1:0]               slot_waddr;
    t_slot_word                   slot_wdata;
    logic [$bits(t_slot_word)-1:0] slot_rdata_raw;
    t_slot_word                   slot_rdata;
    logic                         lvl_we;
    logic [LAW-1:0]               lvl_waddr;
    t_lvl_word                    lvl_wdata;
    logic [$bits(t_lvl_word)-1:0] lvl_rdata_raw;
    t_lvl_word                    lvl_rdata;

    // Shared comparator.
    logic [PRICE_W-1:0] cmp_a, cmp_b;
    t_cmp_res           cmp_res;

    // Scan helpers.
    logic               scanning;
    logic [CW-1:0]      scan_limit;
    logic               issue;
    logic               slot_last, lvl_last;
    logic               is_insert;
    logic [CNT_W-1:0]   dec_orders;

    obbp_ram #(
        .WIDTH ($bits(t_slot_word)),
        .DEPTH (ORDER_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (r_cnt[SAW-1:0]),
        .o_rdata (slot_rdata_raw)
    );

    obbp_ram #(
        .WIDTH ($bits(t_lvl_word)),
        .DEPTH (PRICE_LEVELS)
    ) u_lvl_ram (
        .i_clk   (i_clk),
        .i_we    (lvl_we),
        .i_waddr (lvl_waddr),
        .i_wdata (lvl_wdata),
        .i_raddr (r_cnt[LAW-1:0]),
        .o_rdata (lvl_rdata_raw)
    );

    obbp_cmp u_cmp (
        .i_a   (cmp_a),
        .i_b   (cmp_b),
        .o_res (cmp_res)
    );

    assign slot_rdata = t_slot_word'(slot_rdata_raw);
    assign lvl_rdata  = t_lvl_word'(lvl_rdata_raw);
    assign is_insert  = (r_req.cmd == CMD_INSERT);
    assign slot_last  = (r_rd_idx == CW'(ORDER_SLOTS - 1));
    assign lvl_last   = (r_rd_idx == CW'(PRICE_LEVELS - 1));
    assign dec_orders = (r_lvl_orders != '0) ? (r_lvl_orders - CNT_W'(1)) : '0;

    // Read issue for the three scans: one entry per cycle.
    always_comb begin
        scanning   = (r_state == S_SLOT) || (r_state == S_LVL) || (r_state == S_MAX);
        scan_limit = (r_state == S_SLOT) ? CW'(ORDER_SLOTS) : CW'(PRICE_LEVELS);
        issue      = scanning && (r_cnt < scan_limit);
    end

    // Comparator operand selection.
    always_comb begin
        unique case (r_state)
            S_SLOT: begin
                cmp_a = slot_rdata.id;
                cmp_b = r_req.ord_key;
            end
            S_LVL: begin
                cmp_a = lvl_rdata.price;
                cmp_b = r_target;
            end
            S_MAX: begin
                cmp_a = lvl_rdata.price;
                cmp_b = r_best;
            end
            default: begin
                cmp_a = r_target;
                cmp_b = r_best;
            end
        endcase
    end

    // Sequencer.
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_rd_v       = 1'b0;
        n_rd_idx     = r_cnt;
        n_any        = r_any;
        n_best       = r_best;
        n_req        = r_req;
        n_target     = r_target;
        n_slot_idx   = r_slot_idx;
        n_free_hit   = r_free_hit;
        n_free_idx   = r_free_idx;
        n_lvl_hit    = r_lvl_hit;
        n_lvl_idx    = r_lvl_idx;
        n_lvl_orders = r_lvl_orders;
        n_lfree_hit  = r_lfree_hit;
        n_lfree_idx  = r_lfree_idx;
        n_status     = r_status;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_out_ready;

        slot_we    = 1'b0;
        slot_waddr = r_cnt[SAW-1:0];
        slot_wdata = '0;
        lvl_we     = 1'b0;
        lvl_waddr  = r_cnt[LAW-1:0];
        lvl_wdata  = '0;
        o_in_ready = 1'b0;

        if (issue) begin
            n_rd_v = 1'b1;
            n_cnt  = r_cnt + CW'(1);
        end

        unique case (r_state)
            // Clear every live bit after reset.
            S_CLEAR: begin
                slot_we = (r_cnt < CW'(ORDER_SLOTS));
                lvl_we  = (r_cnt < CW'(PRICE_LEVELS));
                n_cnt   = r_cnt + CW'(1);
                if (r_cnt == CW'(MAX_DEPTH - 1)) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end
            end

            // Wait for a request.
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_req      = i_in_req;
                    n_free_hit = 1'b0;
                    n_cnt      = '0;
                    n_state    = S_SLOT;
                end
            end

            // Scan the order slots for the id and the first free slot.
            S_SLOT: begin
                if (r_rd_v) begin
                    if (slot_rdata.live && cmp_res.eq) begin
                        n_slot_idx  = r_rd_idx[SAW-1:0];
                        n_cnt       = '0;
                        n_rd_v      = 1'b0;
                        if (is_insert) begin
                            n_status = ST_DUP;
                            n_state  = S_OUT;
                        end else begin
                            n_target    = slot_rdata.price;
                            n_lfree_hit = 1'b0;
                            n_state     = S_LVL;
                        end
                    end else begin
                        if (!slot_rdata.live && !r_free_hit) begin
                            n_free_hit = 1'b1;
                            n_free_idx = r_rd_idx[SAW-1:0];
                        end
                        if (slot_last) begin
                            n_cnt  = '0;
                            n_rd_v = 1'b0;
                            if (!is_insert) begin
                                n_status = ST_UNKNOWN;
                                n_state  = S_OUT;
                            end else if (r_free_hit || !slot_rdata.live) begin
                                n_target    = r_req.price;
                                n_lfree_hit = 1'b0;
                                n_state     = S_LVL;
                            end else begin
                                n_status = ST_FULL;
                                n_state  = S_OUT;
                            end
                        end
                    end
                end
            end

            // Scan the price levels for the target price and a free level.
            S_LVL: begin
                if (r_rd_v) begin
                    if (lvl_rdata.live && cmp_res.eq) begin
                        n_lvl_hit    = 1'b1;
                        n_lvl_idx    = r_rd_idx[LAW-1:0];
                        n_lvl_orders = lvl_rdata.orders;
                        n_cnt        = '0;
                        n_rd_v       = 1'b0;
                        if (is_insert && (lvl_rdata.orders >= COUNT_MAX)) begin
                            n_status = ST_FULL;
                            n_state  = S_OUT;
                        end else begin
                            n_state = S_UPD;
                        end
                    end else begin
                        if (!lvl_rdata.live && !r_lfree_hit) begin
                            n_lfree_hit = 1'b1;
                            n_lfree_idx = r_rd_idx[LAW-1:0];
                        end
                        if (lvl_last) begin
                            n_lvl_hit = 1'b0;
                            n_cnt     = '0;
                            n_rd_v    = 1'b0;
                            if (!is_insert || r_lfree_hit || !lvl_rdata.live) begin
                                n_state = S_UPD;
                            end else begin
                                n_status = ST_FULL;
                                n_state  = S_OUT;
                            end
                        end
                    end
                end
            end

            // Commit the change to both tables and update the best price.
            S_UPD: begin
                n_status = ST_APPLIED;
                n_state  = S_OUT;
                slot_we  = 1'b1;
                lvl_we   = 1'b1;
                if (is_insert) begin
                    slot_waddr       = r_free_idx;
                    slot_wdata.live  = 1'b1;
                    slot_wdata.id    = r_req.ord_key;
                    slot_wdata.price = r_req.price;
                    lvl_wdata.live   = 1'b1;
                    lvl_wdata.price  = r_target;
                    if (r_lvl_hit) begin
                        lvl_waddr        = r_lvl_idx;
                        lvl_wdata.orders = r_lvl_orders + CNT_W'(1);
                    end else begin
                        lvl_waddr        = r_lfree_idx;
                        lvl_wdata.orders = CNT_W'(1);
                    end
                    n_any = 1'b1;
                    if (!r_any || cmp_res.gt) begin
                        n_best = r_target;
                    end
                end else begin
                    slot_waddr       = r_slot_idx;
                    slot_wdata.live  = 1'b0;
                    slot_wdata.id    = r_req.ord_key;
                    slot_wdata.price = r_target;
                    lvl_we           = r_lvl_hit;
                    lvl_waddr        = r_lvl_idx;
                    lvl_wdata.live   = (dec_orders != '0);
                    lvl_wdata.orders = dec_orders;
                    lvl_wdata.price  = r_target;
                    // Freeing the top level forces a rescan for the new maximum.
                    if (r_lvl_hit && (dec_orders == '0) && cmp_res.eq) begin
                        n_any   = 1'b0;
                        n_best  = '0;
                        n_cnt   = '0;
                        n_state = S_MAX;
                    end
                end
            end

            // Rescan the live levels for the highest price.
            S_MAX: begin
                if (r_rd_v) begin
                    if (lvl_rdata.live) begin
                        n_any = 1'b1;
                        if (!r_any || cmp_res.gt) begin
                            n_best = lvl_rdata.price;
                        end
                    end
                    if (lvl_last) begin
                        n_cnt   = '0;
                        n_rd_v  = 1'b0;
                        n_state = S_OUT;
                    end
                end
            end

            // Hand the result to the output register once it is free.
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.status     = r_status;
                    n_out.has_price  = r_any;
                    n_out.best_price = r_best;
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end
            end

            default: begin
                n_state = S_CLEAR;
                n_cnt   = '0;
            end
        endcase
    end

    // Control state with synchronous reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_rd_v      <= 1'b0;
            r_out_valid <= 1'b0;
            r_any       <= 1'b0;
            r_best      <= '0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_rd_v      <= n_rd_v;
            r_out_valid <= n_out_valid;
            r_any       <= n_any;
            r_best      <= n_best;
        end
    end

    // Working and payload registers.
    always_ff @(posedge i_clk) begin
        r_rd_idx     <= n_rd_idx;
        r_req        <= n_req;
        r_target     <= n_target;
        r_slot_idx   <= n_slot_idx;
        r_free_hit   <= n_free_hit;
        r_free_idx   <= n_free_idx;
        r_lvl_hit    <= n_lvl_hit;
        r_lvl_idx    <= n_lvl_idx;
        r_lvl_orders <= n_lvl_orders;
        r_lfree_hit  <= n_lfree_hit;
        r_lfree_idx  <= n_lfree_idx;
        r_status     <= n_status;
        r_out        <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

    // An empty book always answers a zero price.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_rsp.has_price) |-> (o_out_rsp.best_price == '0))
        else $error("empty book answered a nonzero price");

    // The level table changes only in the clearing pass or the commit step.
    a_lvl_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lvl_we |-> ((r_state == S_UPD) || (r_state == S_CLEAR)))
        else $error("level table written outside commit or clear");

    // An accepted request always starts the slot scan.
    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_SLOT))
        else $error("accepted request did not start the slot scan");

    // The scan counter never runs past the deeper table.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_DEPTH))
        else $error("scan counter out of range");

endmodule : order_book_best_price
`default_nettype wire

[src/obbp_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// obbp_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module obbp_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule : obbp_ram
`default_nettype wire

[src/obbp_cmp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// obbp_cmp
// Shared price/id comparator used by every scan step of the sequencer.
// ----------------------------------------------------------------------------
module obbp_cmp (
    input  wire logic [obbp_pkg::PRICE_W-1:0] i_a,
    input  wire logic [obbp_pkg::PRICE_W-1:0] i_b,
    output obbp_pkg::t_cmp_res                o_res
);
    import obbp_pkg::*;

    // Equality and unsigned greater-than on the same operand pair.
    always_comb begin
        o_res.eq = (i_a == i_b);
        o_res.gt = (i_a > i_b);
    end

endmodule : obbp_cmp
`default_nettype wire

[tb/tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the order book best price tracker. A short table of
// directed requests covers the empty book, the price extremes, duplicate ids,
// unknown ids and level freeing. Random segments then drive the book toward
// chosen fill targets, including past full. Every response is compared, field
// by field, with a typed quote or a local model of order slots and price levels.
// ----------------------------------------------------------------------------
module tb;
    import obbp_pkg::*;

    localparam int NUM_SLOTS   = DEF_ORDER_SLOTS;
    localparam int NUM_LEVELS  = DEF_PRICE_LEVELS;
    localparam int DIR_N       = 16;
    localparam int RAND_ITEMS  = 1150;
    localparam int QUIET_FROM  = 1000;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 3000;
    localparam int TAIL_CYCLES = 250;

    typedef struct {
        t_req  req;
        bit    typed;
        t_rsp  quote;
    } t_dir_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_ready = 1'b0;
    t_req in_req = '0;
    logic o_in_ready;
    logic o_out_valid;
    t_rsp o_out_rsp;

    // Local copy of the order slots and price levels.
    logic               bk_live  [NUM_SLOTS];
    logic [ID_W-1:0]    bk_id    [NUM_SLOTS];
    logic [PRICE_W-1:0] bk_price [NUM_SLOTS];
    logic               lv_live  [NUM_LEVELS];
    logic [PRICE_W-1:0] lv_price [NUM_LEVELS];
    logic [CNT_W-1:0]   lv_orders[NUM_LEVELS];

    t_rsp               pending_quotes[$];
    t_dir_row           dir_tab[DIR_N];
    logic [PRICE_W-1:0] price_pool[8];
    int                 errors = 0;
    int                 items_sent = 0;
    bit                 quiet = 1'b0;
    bit                 hold_req = 1'b0;
    bit                 hold_done = 1'b0;

    order_book_best_price dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_req   (in_req),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_rsp  (o_out_rsp)
    );

    // Free-running clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Index of the live level that holds the given price, or -1.
    function automatic int level_of(logic [PRICE_W-1:0] p);
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (lv_live[i] && lv_price[i] == p) return i;
        end
        return -1;
    endfunction

    // Applies one request to the local book and returns the expected quote.
    function automatic t_rsp book_apply(t_req r);
        int   s;
        int   l;
        t_rsp q;
        s = -1;
        q = '0;
        q.status = ST_APPLIED;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (bk_live[i] && bk_id[i] == r.ord_key) s = i;
        end
        if (r.cmd == CMD_INSERT) begin
            if (s >= 0) begin
                q.status = ST_DUP;
            end else begin
                for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
                    if (!bk_live[i]) s = i;
                end
                if (s < 0) begin
                    q.status = ST_FULL;
                end else begin
                    l = level_of(r.price);
                    if (l >= 0) begin
                        if (lv_orders[l] >= COUNT_MAX) q.status = ST_FULL;
                        else lv_orders[l] = lv_orders[l] + 1'b1;
                    end else begin
                        for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
                            if (!lv_live[i]) l = i;
                        end
                        if (l < 0) begin
                            q.status = ST_FULL;
                        end else begin
                            lv_live[l]   = 1'b1;
                            lv_price[l]  = r.price;
                            lv_orders[l] = 1;
                        end
                    end
                    if (q.status == ST_APPLIED) begin
                        bk_live[s]  = 1'b1;
                        bk_id[s]    = r.ord_key;
                        bk_price[s] = r.price;
                    end
                end
            end
        end else begin
            if (s < 0) begin
                q.status = ST_UNKNOWN;
            end else begin
                bk_live[s] = 1'b0;
                l = level_of(bk_price[s]);
                if (l >= 0) begin
                    if (lv_orders[l] > 0) lv_orders[l] = lv_orders[l] - 1'b1;
                    if (lv_orders[l] == 0) lv_live[l] = 1'b0;
                end
            end
        end
        // Best price over the live levels.
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (lv_live[i]) begin
                if (!q.has_price || lv_price[i] > q.best_price) q.best_price = lv_price[i];
                q.has_price = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic int live_orders();
        int n;
        n = 0;
        for (int i = 0; i < NUM_SLOTS; i++) n += bk_live[i];
        return n;
    endfunction

    // Id of some live order; the caller makes sure one exists.
    function automatic logic [ID_W-1:0] pick_live_id();
        int k;
        k = $urandom_range(0, NUM_SLOTS - 1);
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (bk_live[(k + i) % NUM_SLOTS]) return bk_id[(k + i) % NUM_SLOTS];
        end
        return '0;
    endfunction

    function automatic t_dir_row dir_row(t_cmd c, logic [ID_W-1:0] id,
                                         logic [PRICE_W-1:0] p, bit typed,
                                         t_status st, logic has,
                                         logic [PRICE_W-1:0] best);
        t_dir_row row;
        row.req.cmd          = c;
        row.req.ord_key      = id;
        row.req.price        = p;
        row.typed            = typed;
        row.quote.status     = st;
        row.quote.has_price  = has;
        row.quote.best_price = best;
        return row;
    endfunction

    // Builds one random request, steering the book toward a fill target.
    function automatic t_req make_request(int target);
        t_req r;
        int   n;
        bit   ins;
        n = live_orders();
        ins = (n < target) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 3) == 0);
        r.price = ($urandom_range(0, 1) == 0) ? price_pool[$urandom_range(0, 7)] : $urandom();
        if (ins) begin
            r.cmd = CMD_INSERT;
            if (n > 0 && $urandom_range(0, 9) == 0) r.ord_key = pick_live_id();
            else r.ord_key = $urandom();
        end else begin
            r.cmd = CMD_ERASE;
            if (n > 0 && $urandom_range(0, 7) != 0) r.ord_key = pick_live_id();
            else r.ord_key = $urandom();
        end
        return r;
    endfunction

    // Offers one request, waits for it to be taken and records its quote.
    task automatic send_request(t_req r, bit typed, t_rsp typed_quote);
        t_rsp q;
        in_req   <= r;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        q = book_apply(r);
        pending_quotes.push_back(typed ? typed_quote : q);
        items_sent++;
        if (items_sent >= QUIET_FROM) quiet = 1'b1;
        if (items_sent >= HOLD_AT && !hold_done) begin
            hold_done = 1'b1;
            hold_req  = 1'b1;
        end
    endtask

    // Random gap on the request side.
    task automatic sender_pause();
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    task automatic check_field(string name, logic [PRICE_W-1:0] want, logic [PRICE_W-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Directed table: typed quotes where they are obvious, the rest predicted.
    initial begin
        dir_tab[0]  = dir_row(CMD_ERASE,  32'h0000_0000, 32'h0000_0000, 1, ST_UNKNOWN, 0, 32'h0);
        dir_tab[1]  = dir_row(CMD_INSERT, 32'h0000_0000, 32'h0000_0000, 1, ST_APPLIED, 1, 32'h0);
        dir_tab[2]  = dir_row(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, ST_APPLIED, 1,
                              32'hFFFF_FFFF);
        dir_tab[3]  = dir_row(CMD_INSERT, 32'h0000_0000, 32'h0000_0005, 1, ST_DUP, 1,
                              32'hFFFF_FFFF);
        dir_tab[4]  = dir_row(CMD_INSERT, 32'h0000_0001, 32'hFFFF_FFFF, 1, ST_APPLIED, 1,
                              32'hFFFF_FFFF);
        dir_tab[5]  = dir_row(CMD_ERASE,  32'hFFFF_FFFF, 32'h0000_0000, 1, ST_APPLIED, 1,
                              32'hFFFF_FFFF);
        dir_tab[6]  = dir_row(CMD_ERASE,  32'h0000_0001, 32'h0000_0000, 1, ST_APPLIED, 1, 32'h0);
        dir_tab[7]  = dir_row(CMD_ERASE,  32'h0000_0001, 32'hFFFF_FFFF, 1, ST_UNKNOWN, 1, 32'h0);
        dir_tab[8]  = dir_row(CMD_ERASE,  32'h0000_0000, 32'hFFFF_FFFF, 1, ST_APPLIED, 0, 32'h0);
        dir_tab[9]  = dir_row(CMD_INSERT, 32'h1234_5678, 32'hA5A5_A5A5, 0, ST_APPLIED, 0, 32'h0);
        dir_tab[10] = dir_row(CMD_INSERT, 32'h8765_4321, 32'h5A5A_5A5A, 0, ST_APPLIED, 0, 32'h0);
        dir_tab[11] = dir_row(CMD_INSERT, 32'hAAAA_AAAA, 32'h5A5A_5A5A, 0, ST_APPLIED, 0, 32'h0);
        dir_tab[12] = dir_row(CMD_ERASE,  32'h1234_5678, 32'h0000_0000, 0, ST_APPLIED, 0, 32'h0);
        dir_tab[13] = dir_row(CMD_ERASE,  32'h8765_4321, 32'h0000_0000, 0, ST_APPLIED, 0, 32'h0);
        dir_tab[14] = dir_row(CMD_ERASE,  32'hAAAA_AAAA, 32'h0000_0000, 0, ST_APPLIED, 0, 32'h0);
        dir_tab[15] = dir_row(CMD_ERASE,  32'h5555_5555, 32'h5555_5555, 1, ST_UNKNOWN, 0, 32'h0);
    end

    // Request side: reset, directed table, random segments, then drain.
    initial begin
        int seg_left;
        int target;
        t_rsp none;
        none = '0;
        seg_left = 200;
        target = NUM_SLOTS + 16;
        for (int i = 0; i < NUM_SLOTS; i++) bk_live[i] = 1'b0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            lv_live[i]   = 1'b0;
            lv_orders[i] = '0;
        end
        for (int i = 0; i < 8; i++) price_pool[i] = $urandom();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int k = 0; k < DIR_N; k++) begin
            send_request(dir_tab[k].req, dir_tab[k].typed, dir_tab[k].quote);
            sender_pause();
        end
        // The first segment overfills the book so that full refusals show up early.
        while (items_sent < RAND_ITEMS) begin
            if (seg_left == 0) begin
                case ($urandom_range(0, 4))
                    0: target = 0;
                    1: target = $urandom_range(1, 6);
                    2: target = $urandom_range(16, 40);
                    3: target = NUM_SLOTS;
                    default: target = NUM_SLOTS + 16;
                endcase
                seg_left = (target >= NUM_SLOTS) ? 200 : $urandom_range(40, 120);
                for (int i = 0; i < 8; i++) begin
                    price_pool[i] = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom();
                end
                if ($urandom_range(0, 3) == 0) price_pool[7] = 32'h0;
            end
            send_request(make_request(target), 1'b0, none);
            seg_left--;
            sender_pause();
        end
        in_valid <= 1'b0;
        while (pending_quotes.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Response side: random stalls, one long hold-off, none near the end.
    initial begin
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++) @(posedge i_clk);
            end else if (quiet) begin
                out_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end
        end
    end

    // Compare each accepted quote with the oldest pending one.
    always @(posedge i_clk) begin : quote_check
        t_rsp want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (pending_quotes.size() == 0) begin
                errors++;
                $display("%0t: unexpected response, expected none, actual %0h",
                         $time, o_out_rsp);
            end else begin
                want = pending_quotes.pop_front();
                check_field("status", 32'(want.status), 32'(o_out_rsp.status));
                check_field("has_price", 32'(want.has_price), 32'(o_out_rsp.has_price));
                check_field("best_price", want.best_price, o_out_rsp.best_price);
            end
        end
    end

endmodule : tb
`default_nettype wire

[files.f]
src/obbp_pkg.sv
src/obbp_ram.sv
src/obbp_cmp.sv
src/order_book_best_price.sv
tb/tb.sv
